>>> hdl/ptd_pkg.sv
// Shared constants, codes and controller/datapath interface types for the task dispatcher.
`timescale 1ns / 1ps
package ptd_pkg;

   localparam int MAX_TASKS = 16;
   localparam int IDX_W     = 4;
   localparam int CNT_W     = 5;
   localparam int FUNC_W    = 3;
   localparam int PERIOD_W  = 31;
   localparam int TIME_W    = 32;

   typedef enum logic [FUNC_W-1:0] {
      FN_DISPATCH   = 3'd0,
      FN_SET_PERIOD = 3'd1,
      FN_ENABLE     = 3'd2,
      FN_DISABLE    = 3'd3,
      FN_COMPLETE   = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_BAD_INDEX = 2'd1,
      STAT_NO_RUN    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_DSP_WR,
      ST_CPL_CALC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       load_item;
      logic       scan_issue;
      logic       dsp_capture;
      logic       dsp_commit;
      logic       set_write;
      logic       cpl_commit;
      logic       status_load;
      status_type status_code;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              idx_bad;
      logic              run_valid;
      logic              scan_more;
      logic              eval_hit;
      logic              eval_done;
      logic              rsp_free;
   } stat_type;

endpackage

>>> hdl/ptd_ctrl.sv
// Controller state machine sequencing decode, table scan, commits and result transfer.
`timescale 1ns / 1ps
module ptd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ptd_pkg::stat_type stat,
   output ptd_pkg::cmd_type  cmd
);

   ptd_pkg::state_type state_ff;
   ptd_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptd_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ptd_pkg::ST_DECODE;
            end
         end
         ptd_pkg::ST_DECODE: begin
            case (stat.func)
               ptd_pkg::FN_DISPATCH: begin
                  state_in = stat.scan_more ? ptd_pkg::ST_SCAN : ptd_pkg::ST_FINISH;
               end
               ptd_pkg::FN_COMPLETE: begin
                  state_in = stat.run_valid ? ptd_pkg::ST_CPL_CALC : ptd_pkg::ST_FINISH;
               end
               default: begin
                  state_in = ptd_pkg::ST_FINISH;
               end
            endcase
         end
         ptd_pkg::ST_SCAN: begin
            if (stat.eval_hit) begin
               state_in = ptd_pkg::ST_DSP_WR;
            end else if (stat.eval_done) begin
               state_in = ptd_pkg::ST_FINISH;
            end
         end
         ptd_pkg::ST_DSP_WR: begin
            state_in = ptd_pkg::ST_FINISH;
         end
         ptd_pkg::ST_CPL_CALC: begin
            state_in = ptd_pkg::ST_FINISH;
         end
         ptd_pkg::ST_FINISH: begin
            if (stat.rsp_free) begin
               state_in = ptd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd             = '0;
      cmd.status_code = ptd_pkg::STAT_OK;
      req_ready       = 1'b0;
      unique case (state_ff)
         ptd_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ptd_pkg::ST_DECODE: begin
            case (stat.func) inside
               ptd_pkg::FN_SET_PERIOD, ptd_pkg::FN_ENABLE, ptd_pkg::FN_DISABLE: begin
                  if (stat.idx_bad) begin
                     cmd.status_load = 1'b1;
                     cmd.status_code = ptd_pkg::STAT_BAD_INDEX;
                  end else begin
                     cmd.set_write = 1'b1;
                  end
               end
               ptd_pkg::FN_COMPLETE: begin
                  if (!stat.run_valid) begin
                     cmd.status_load = 1'b1;
                     cmd.status_code = ptd_pkg::STAT_NO_RUN;
                  end
               end
               default: begin
               end
            endcase
         end
         ptd_pkg::ST_SCAN: begin
            cmd.scan_issue  = stat.scan_more;
            cmd.dsp_capture = stat.eval_hit;
         end
         ptd_pkg::ST_DSP_WR: begin
            cmd.dsp_commit = 1'b1;
         end
         ptd_pkg::ST_CPL_CALC: begin
            cmd.cpl_commit = 1'b1;
         end
         ptd_pkg::ST_FINISH: begin
            cmd.out_load = stat.rsp_free;
         end
         default: begin
         end
      endcase
   end

endmodule

>>> hdl/ptd_datapath.sv
// Datapath: item and config registers, task tables, scan compare, busy statistics, result register.
`timescale 1ns / 1ps
module ptd_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  ptd_pkg::cmd_type                   cmd,
   output ptd_pkg::stat_type                  stat,
   input  logic [ptd_pkg::FUNC_W-1:0]         req_func,
   input  logic [ptd_pkg::IDX_W-1:0]          req_task_index,
   input  logic [ptd_pkg::PERIOD_W-1:0]       req_new_period,
   input  logic [ptd_pkg::TIME_W-1:0]         req_time_now,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ptd_pkg::CNT_W-1:0]          csr_tasks_in_use,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_dispatched,
   output logic [ptd_pkg::IDX_W-1:0]          rsp_chosen_task,
   output logic signed [ptd_pkg::TIME_W-1:0]  rsp_measured_period,
   output logic [ptd_pkg::TIME_W-1:0]         rsp_total_busy,
   output logic [ptd_pkg::TIME_W-1:0]         rsp_peak_busy,
   output logic [1:0]                         rsp_status
);

   // configuration
   logic [ptd_pkg::CNT_W-1:0] tiu_ff;
   logic [ptd_pkg::CNT_W-1:0] count_eff;

   // item
   logic [ptd_pkg::FUNC_W-1:0]   item_func_ff;
   logic [ptd_pkg::IDX_W-1:0]    item_idx_ff;
   logic [ptd_pkg::PERIOD_W-1:0] item_period_ff;
   logic [ptd_pkg::TIME_W-1:0]   item_time_ff;

   // tables
   logic [ptd_pkg::PERIOD_W-1:0] period_mem [ptd_pkg::MAX_TASKS];
   logic [ptd_pkg::TIME_W-1:0]   stamp_mem  [ptd_pkg::MAX_TASKS];
   logic [ptd_pkg::TIME_W-1:0]   total_mem  [ptd_pkg::MAX_TASKS];
   logic [ptd_pkg::TIME_W-1:0]   peak_mem   [ptd_pkg::MAX_TASKS];
   logic [ptd_pkg::MAX_TASKS-1:0] period_vld_ff;
   logic [ptd_pkg::MAX_TASKS-1:0] stamp_vld_ff;
   logic [ptd_pkg::MAX_TASKS-1:0] busy_vld_ff;
   logic [ptd_pkg::MAX_TASKS-1:0] enable_ff;
   logic period_we;
   logic enable_we;

   // scan
   logic [ptd_pkg::CNT_W-1:0]    scan_ptr_ff;
   logic [ptd_pkg::IDX_W-1:0]    scan_idx;
   logic                         eval_vld_ff;
   logic [ptd_pkg::IDX_W-1:0]    eval_idx_ff;
   logic [ptd_pkg::PERIOD_W-1:0] rd_period_ff;
   logic                         rd_period_vld_ff;
   logic [ptd_pkg::TIME_W-1:0]   rd_stamp_ff;
   logic                         rd_stamp_vld_ff;
   logic [ptd_pkg::PERIOD_W-1:0] eval_period;
   logic [ptd_pkg::TIME_W-1:0]   eval_stamp;
   logic [ptd_pkg::TIME_W-1:0]   eval_elapsed;
   logic                         eval_hit;
   logic                         eval_last;

   // running task and busy statistics
   logic                         run_valid_ff;
   logic [ptd_pkg::IDX_W-1:0]    run_idx_ff;
   logic [ptd_pkg::TIME_W-1:0]   run_start_ff;
   logic [ptd_pkg::TIME_W-1:0]   cpl_ex_ff;
   logic [ptd_pkg::TIME_W-1:0]   rd_total_ff;
   logic [ptd_pkg::TIME_W-1:0]   rd_peak_ff;
   logic                         rd_busy_vld_ff;
   logic [ptd_pkg::TIME_W-1:0]   cur_total;
   logic [ptd_pkg::TIME_W-1:0]   cur_peak;
   logic [ptd_pkg::TIME_W-1:0]   new_total;
   logic [ptd_pkg::TIME_W-1:0]   new_peak;

   // result staging and output
   logic                         res_dispatched_ff;
   logic [ptd_pkg::IDX_W-1:0]    res_task_ff;
   logic [ptd_pkg::TIME_W-1:0]   res_measured_ff;
   logic [ptd_pkg::TIME_W-1:0]   res_total_ff;
   logic [ptd_pkg::TIME_W-1:0]   res_peak_ff;
   ptd_pkg::status_type          res_status_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic                         rsp_free;
   logic                         out_dispatched_ff;
   logic [ptd_pkg::IDX_W-1:0]    out_task_ff;
   logic [ptd_pkg::TIME_W-1:0]   out_measured_ff;
   logic [ptd_pkg::TIME_W-1:0]   out_total_ff;
   logic [ptd_pkg::TIME_W-1:0]   out_peak_ff;
   logic [1:0]                   out_status_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tiu_ff <= '0;
      end else if (csr_valid) begin
         tiu_ff <= csr_tasks_in_use;
      end
   end

   assign count_eff = (tiu_ff > ptd_pkg::CNT_W'(ptd_pkg::MAX_TASKS)) ?
                      ptd_pkg::CNT_W'(ptd_pkg::MAX_TASKS) : tiu_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_func_ff   <= req_func;
         item_idx_ff    <= req_task_index;
         item_period_ff <= req_new_period;
         item_time_ff   <= req_time_now;
      end
   end

   // period and enable writes
   assign period_we = cmd.set_write && (item_func_ff == ptd_pkg::FN_SET_PERIOD);
   assign enable_we = cmd.set_write && ((item_func_ff == ptd_pkg::FN_ENABLE) ||
                                        (item_func_ff == ptd_pkg::FN_DISABLE));

   always_ff @(posedge clock) begin
      if (period_we) begin
         period_mem[item_idx_ff] <= item_period_ff;
      end
      if (cmd.scan_issue) begin
         rd_period_ff <= period_mem[scan_idx];
         rd_stamp_ff  <= stamp_mem[scan_idx];
      end
      if (cmd.dsp_commit) begin
         stamp_mem[res_task_ff] <= item_time_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_vld_ff <= '0;
         stamp_vld_ff  <= '0;
         enable_ff     <= '0;
      end else begin
         if (period_we) begin
            period_vld_ff[item_idx_ff] <= 1'b1;
         end
         if (enable_we) begin
            enable_ff[item_idx_ff] <= (item_func_ff == ptd_pkg::FN_ENABLE);
         end
         if (cmd.dsp_commit) begin
            stamp_vld_ff[res_task_ff] <= 1'b1;
         end
      end
   end

   // scan pipeline: read one entry per cycle, compare it the cycle after
   assign scan_idx = scan_ptr_ff[ptd_pkg::IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ptr_ff <= '0;
         eval_vld_ff <= 1'b0;
      end else begin
         if (cmd.load_item) begin
            scan_ptr_ff <= '0;
         end else if (cmd.scan_issue) begin
            scan_ptr_ff <= scan_ptr_ff + ptd_pkg::CNT_W'(1);
         end
         eval_vld_ff <= cmd.scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_issue) begin
         eval_idx_ff      <= scan_idx;
         rd_period_vld_ff <= period_vld_ff[scan_idx];
         rd_stamp_vld_ff  <= stamp_vld_ff[scan_idx];
      end
   end

   assign eval_period  = rd_period_vld_ff ? rd_period_ff : '0;
   assign eval_stamp   = rd_stamp_vld_ff ? rd_stamp_ff : '0;
   assign eval_elapsed = item_time_ff - eval_stamp;
   assign eval_hit     = eval_vld_ff && enable_ff[eval_idx_ff] &&
                         ($signed(eval_elapsed) > $signed({1'b0, eval_period}));
   assign eval_last    = ((ptd_pkg::CNT_W'(eval_idx_ff) + ptd_pkg::CNT_W'(1)) == count_eff);

   // running task
   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= 1'b0;
         run_idx_ff   <= '0;
         run_start_ff <= '0;
      end else if (cmd.dsp_commit) begin
         run_valid_ff <= 1'b1;
         run_idx_ff   <= res_task_ff;
         run_start_ff <= item_time_ff;
      end else if (cmd.cpl_commit) begin
         run_valid_ff <= 1'b0;
      end
   end

   // busy statistics, read continuously at the running index
   always_ff @(posedge clock) begin
      cpl_ex_ff   <= item_time_ff - run_start_ff;
      rd_total_ff <= total_mem[run_idx_ff];
      rd_peak_ff  <= peak_mem[run_idx_ff];
      if (cmd.cpl_commit) begin
         total_mem[run_idx_ff] <= new_total;
         peak_mem[run_idx_ff]  <= new_peak;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_vld_ff    <= '0;
         rd_busy_vld_ff <= 1'b0;
      end else begin
         rd_busy_vld_ff <= busy_vld_ff[run_idx_ff];
         if (cmd.cpl_commit) begin
            busy_vld_ff[run_idx_ff] <= 1'b1;
         end
      end
   end

   assign cur_total = rd_busy_vld_ff ? rd_total_ff : '0;
   assign cur_peak  = rd_busy_vld_ff ? rd_peak_ff : '0;
   assign new_total = cur_total + cpl_ex_ff;
   assign new_peak  = (cpl_ex_ff > cur_peak) ? cpl_ex_ff : cur_peak;

   // result staging
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         res_dispatched_ff <= 1'b0;
         res_task_ff       <= '0;
         res_measured_ff   <= '0;
         res_total_ff      <= '0;
         res_peak_ff       <= '0;
         res_status_ff     <= ptd_pkg::STAT_OK;
      end else begin
         if (cmd.dsp_capture) begin
            res_dispatched_ff <= 1'b1;
            res_task_ff       <= eval_idx_ff;
            res_measured_ff   <= eval_elapsed;
         end
         if (cmd.cpl_commit) begin
            res_task_ff  <= run_idx_ff;
            res_total_ff <= new_total;
            res_peak_ff  <= new_peak;
         end
         if (cmd.status_load) begin
            res_status_ff <= cmd.status_code;
         end
      end
   end

   // output register
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_dispatched_ff <= res_dispatched_ff;
         out_task_ff       <= res_task_ff;
         out_measured_ff   <= res_measured_ff;
         out_total_ff      <= res_total_ff;
         out_peak_ff       <= res_peak_ff;
         out_status_ff     <= res_status_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_dispatched      = out_dispatched_ff;
   assign rsp_chosen_task     = out_task_ff;
   assign rsp_measured_period = $signed(out_measured_ff);
   assign rsp_total_busy      = out_total_ff;
   assign rsp_peak_busy       = out_peak_ff;
   assign rsp_status          = out_status_ff;

   assign stat.func      = item_func_ff;
   assign stat.idx_bad   = (ptd_pkg::CNT_W'(item_idx_ff) >= count_eff);
   assign stat.run_valid = run_valid_ff;
   assign stat.scan_more = (scan_ptr_ff < count_eff);
   assign stat.eval_hit  = eval_hit;
   assign stat.eval_done = eval_vld_ff && eval_last && !eval_hit;
   assign stat.rsp_free  = rsp_free;

   a_dsp_sets_run: assert property (@(posedge clock) disable iff (reset)
      cmd.dsp_commit |=> run_valid_ff && (run_idx_ff == $past(res_task_ff)))
      else $error("dispatch commit did not mark the task running");

   a_cpl_clears_run: assert property (@(posedge clock) disable iff (reset)
      cmd.cpl_commit |=> !run_valid_ff)
      else $error("completion left a task running");

   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> rsp_free)
      else $error("result loaded over an untaken transfer");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_issue |-> (scan_ptr_ff < count_eff))
      else $error("scan read past the tasks in use");

endmodule

>>> hdl/periodic_task_dispatcher.sv
// Top level of the periodic task dispatcher: controller plus datapath.
// One item at a time. Period set, enable, disable, rejected and unused items pass
// through decode straight to finish; a completion passes through a commit state
// first. A dispatch scans the tasks in use one table entry per cycle through a
// registered read, with N = min(tasks_in_use, 16); the scan is skipped when N is 0
// and stops at the first task that fires. The next item is taken the cycle after its
// result is loaded. A finished result sits in the output register while the next item
// is taken, and the next result waits in the controller until that transfer happens.
// The configuration port is always ready; the user must write it only while no item
// is in flight, and the block itself does not enforce this.
`timescale 1ns / 1ps
module periodic_task_dispatcher (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ptd_pkg::FUNC_W-1:0]         req_func,
   input  logic [ptd_pkg::IDX_W-1:0]          req_task_index,
   input  logic [ptd_pkg::PERIOD_W-1:0]       req_new_period,
   input  logic [ptd_pkg::TIME_W-1:0]         req_time_now,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_dispatched,
   output logic [ptd_pkg::IDX_W-1:0]          rsp_chosen_task,
   output logic signed [ptd_pkg::TIME_W-1:0]  rsp_measured_period,
   output logic [ptd_pkg::TIME_W-1:0]         rsp_total_busy,
   output logic [ptd_pkg::TIME_W-1:0]         rsp_peak_busy,
   output logic [1:0]                         rsp_status,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ptd_pkg::CNT_W-1:0]          csr_tasks_in_use
);

   ptd_pkg::cmd_type  cmd;
   ptd_pkg::stat_type stat;

   ptd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptd_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_func            (req_func),
      .req_task_index      (req_task_index),
      .req_new_period      (req_new_period),
      .req_time_now        (req_time_now),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_tasks_in_use    (csr_tasks_in_use),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_dispatched      (rsp_dispatched),
      .rsp_chosen_task     (rsp_chosen_task),
      .rsp_measured_period (rsp_measured_period),
      .rsp_total_busy      (rsp_total_busy),
      .rsp_peak_busy       (rsp_peak_busy),
      .rsp_status          (rsp_status)
   );

endmodule

>>> bench/testbench.sv
// Self-checking bench for the periodic task dispatcher: directed table, then random traffic.
`timescale 1ns / 1ps
module testbench;
   import ptd_pkg::*;

   localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 106;
   localparam int SQUEEZE_AT   = 300;
   localparam int SQUEEZE_LEN  = 400;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [IDX_W-1:0]    idx;
      logic [PERIOD_W-1:0] period;
      logic [TIME_W-1:0]   now;
   } request_t;

   typedef struct packed {
      logic              dispatched;
      logic [IDX_W-1:0]  chosen;
      logic [TIME_W-1:0] measured;
      logic [TIME_W-1:0] total;
      logic [TIME_W-1:0] peak;
      logic [1:0]        status;
   } report_t;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind;

   typedef struct packed {
      row_kind          kind;
      logic             pinned;
      logic [CNT_W-1:0] setting;
      request_t         rq;
      report_t          want;
   } script_row;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [FUNC_W-1:0]     req_func = '0;
   logic [IDX_W-1:0]      req_task_index = '0;
   logic [PERIOD_W-1:0]   req_new_period = '0;
   logic [TIME_W-1:0]     req_time_now = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_dispatched;
   logic [IDX_W-1:0]      rsp_chosen_task;
   logic signed [TIME_W-1:0] rsp_measured_period;
   logic [TIME_W-1:0]     rsp_total_busy;
   logic [TIME_W-1:0]     rsp_peak_busy;
   logic [1:0]            rsp_status;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CNT_W-1:0]      csr_tasks_in_use = '0;

   // dispatcher state as the bench sees it
   logic [PERIOD_W-1:0] period_us  [MAX_TASKS];
   logic                task_on    [MAX_TASKS];
   logic [TIME_W-1:0]   last_start [MAX_TASKS];
   logic [TIME_W-1:0]   busy_sum   [MAX_TASKS];
   logic [TIME_W-1:0]   busy_max   [MAX_TASKS];
   logic                live;
   logic [IDX_W-1:0]    live_task;
   logic [TIME_W-1:0]   live_since;
   logic [CNT_W-1:0]    task_limit;

   report_t     due_reports[$];
   script_row   script[$];
   logic [TIME_W-1:0] now_us;
   bit          bursts_on = 1'b1;
   bit          after_dispatch = 1'b0;
   int unsigned faults = 0;
   int unsigned requests_sent = 0;
   int unsigned reports_seen = 0;
   int unsigned settings_used = 0;
   int unsigned fired = 0;
   int unsigned closed = 0;
   int unsigned rejected = 0;
   int unsigned orphans = 0;

   periodic_task_dispatcher dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_task_index      (req_task_index),
      .req_new_period      (req_new_period),
      .req_time_now        (req_time_now),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_dispatched      (rsp_dispatched),
      .rsp_chosen_task     (rsp_chosen_task),
      .rsp_measured_period (rsp_measured_period),
      .rsp_total_busy      (rsp_total_busy),
      .rsp_peak_busy       (rsp_peak_busy),
      .rsp_status          (rsp_status),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_tasks_in_use    (csr_tasks_in_use)
   );

   always #10 clock = ~clock;

   function automatic report_t apply_request(input request_t rq);
      report_t     rep;
      int          span;
      logic [TIME_W-1:0] gap;
      logic        hit;
      rep = '0;
      hit = 1'b0;
      span = (task_limit > MAX_TASKS) ? MAX_TASKS : int'(task_limit);
      case (rq.func)
         FN_DISPATCH: begin
            for (int k = 0; k < MAX_TASKS; k++) begin
               gap = rq.now - last_start[k];
               if (!hit && k < span && task_on[k] &&
                   $signed(gap) > $signed({1'b0, period_us[k]})) begin
                  hit = 1'b1;
                  last_start[k] = rq.now;
                  live = 1'b1;
                  live_task = k[IDX_W-1:0];
                  live_since = rq.now;
                  rep.dispatched = 1'b1;
                  rep.chosen = k[IDX_W-1:0];
                  rep.measured = gap;
                  fired++;
               end
            end
         end
         FN_SET_PERIOD, FN_ENABLE, FN_DISABLE: begin
            if (int'(rq.idx) >= span) begin
               rep.status = STAT_BAD_INDEX;
               rejected++;
            end else if (rq.func == FN_SET_PERIOD) begin
               period_us[rq.idx] = rq.period;
            end else begin
               task_on[rq.idx] = (rq.func == FN_ENABLE);
            end
         end
         FN_COMPLETE: begin
            if (!live) begin
               rep.status = STAT_NO_RUN;
               orphans++;
            end else begin
               gap = rq.now - live_since;
               busy_sum[live_task] = busy_sum[live_task] + gap;
               if (gap > busy_max[live_task]) busy_max[live_task] = gap;
               live = 1'b0;
               rep.chosen = live_task;
               rep.total = busy_sum[live_task];
               rep.peak = busy_max[live_task];
               closed++;
            end
         end
         default: ;
      endcase
      return rep;
   endfunction

   function automatic request_t random_request();
      request_t    rq;
      int unsigned pick;
      int          span;
      span = (task_limit > MAX_TASKS) ? MAX_TASKS : int'(task_limit);
      pick = $urandom_range(0, 99);
      now_us = now_us + $urandom_range(0, 60);
      rq.now = now_us;
      rq.idx = IDX_W'($urandom_range(0, MAX_TASKS - 1));
      rq.period = PERIOD_W'($urandom_range(0, 200));
      if (after_dispatch && $urandom_range(0, 1) == 0) rq.func = FN_COMPLETE;
      else if (pick < 36) rq.func = FN_DISPATCH;
      else if (pick < 58) rq.func = FN_COMPLETE;
      else if (pick < 73) rq.func = FN_SET_PERIOD;
      else if (pick < 88) rq.func = FN_ENABLE;
      else if (pick < 95) rq.func = FN_DISABLE;
      else rq.func = FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
      if (span > 0 && $urandom_range(0, 7) != 0) rq.idx = IDX_W'($urandom_range(0, span - 1));
      case ($urandom_range(0, 15))
         0: rq.period = PERIOD_W'($urandom);
         1: rq.period = '1;
         2: rq.period = '0;
         default: ;
      endcase
      if (rq.func == FN_COMPLETE && $urandom_range(0, 19) == 0) rq.now = $urandom;
      if (rq.func == FN_DISPATCH && $urandom_range(0, 99) == 0) rq.now = $urandom;
      if (rq.func inside {[FN_SPARE_LO:FN_SPARE_HI]} || $urandom_range(0, 49) == 0) begin
         rq.now = $urandom;
         rq.period = PERIOD_W'($urandom);
      end
      after_dispatch = (rq.func == FN_DISPATCH);
      return rq;
   endfunction

   task automatic add_req(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] i,
                          input logic [PERIOD_W-1:0] p, input logic [TIME_W-1:0] t);
      script_row row;
      row = '0;
      row.kind = ROW_REQ;
      row.rq = '{func: f, idx: i, period: p, now: t};
      script.push_back(row);
   endtask

   task automatic add_chk(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] i,
                          input logic [PERIOD_W-1:0] p, input logic [TIME_W-1:0] t,
                          input logic d, input logic [IDX_W-1:0] c,
                          input logic [TIME_W-1:0] m, input logic [TIME_W-1:0] tot,
                          input logic [TIME_W-1:0] pk, input logic [1:0] st);
      script_row row;
      row = '0;
      row.kind = ROW_REQ;
      row.pinned = 1'b1;
      row.rq = '{func: f, idx: i, period: p, now: t};
      row.want = '{dispatched: d, chosen: c, measured: m, total: tot, peak: pk, status: st};
      script.push_back(row);
   endtask

   task automatic add_csr(input logic [CNT_W-1:0] v);
      script_row row;
      row = '0;
      row.kind = ROW_CSR;
      row.setting = v;
      script.push_back(row);
   endtask

   task automatic offer(input request_t rq, input logic pinned, input report_t want);
      report_t guess;
      if (bursts_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= rq.func;
      req_task_index <= rq.idx;
      req_new_period <= rq.period;
      req_time_now <= rq.now;
      do @(posedge clock); while (!req_ready);
      guess = apply_request(rq);
      due_reports.push_back(pinned ? want : guess);
      requests_sent++;
   endtask

   task automatic write_tasks_in_use(input logic [CNT_W-1:0] v);
      req_valid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_tasks_in_use <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      task_limit = v;
      settings_used++;
   endtask

   task automatic note(input string what, input logic [TIME_W-1:0] want,
                       input logic [TIME_W-1:0] got);
      faults++;
      $display("%0t ns: %s expected %h, got %h", $time, what, want, got);
   endtask

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin : sink
      int unsigned hold;
      bit          squeezed;
      report_t     got;
      report_t     want;
      hold = 0;
      squeezed = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got = '{dispatched: rsp_dispatched, chosen: rsp_chosen_task,
                    measured: rsp_measured_period, total: rsp_total_busy,
                    peak: rsp_peak_busy, status: rsp_status};
            reports_seen++;
            if (due_reports.size() == 0) begin
               faults++;
               $display("%0t ns: result transfer with nothing expected", $time);
            end else begin
               want = due_reports.pop_front();
               if (got.dispatched !== want.dispatched)
                  note("dispatched", want.dispatched, got.dispatched);
               if (got.chosen !== want.chosen) note("chosen_task", want.chosen, got.chosen);
               if (got.measured !== want.measured)
                  note("measured_period", want.measured, got.measured);
               if (got.total !== want.total) note("total_busy", want.total, got.total);
               if (got.peak !== want.peak) note("peak_busy", want.peak, got.peak);
               if (got.status !== want.status) note("status", want.status, got.status);
            end
         end
         if (hold != 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (!squeezed && requests_sent >= SQUEEZE_AT) begin
            squeezed = 1'b1;
            hold = SQUEEZE_LEN - 1;
            rsp_ready <= 1'b0;
         end else if (bursts_on && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(0, 15);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      logic [CNT_W-1:0] phase_cfg [PHASES];
      for (int k = 0; k < MAX_TASKS; k++) begin
         period_us[k] = '0;
         task_on[k] = 1'b0;
         last_start[k] = '0;
         busy_sum[k] = '0;
         busy_max[k] = '0;
      end
      live = 1'b0;
      live_task = '0;
      live_since = '0;
      task_limit = '0;

      // nothing in use after reset
      add_chk(FN_DISPATCH, 0, 0, 0, 0, 0, 0, 0, 0, STAT_OK);
      add_chk(FN_SET_PERIOD, 0, 100, 0, 0, 0, 0, 0, 0, STAT_BAD_INDEX);
      add_chk(FN_ENABLE, 15, 0, 0, 0, 0, 0, 0, 0, STAT_BAD_INDEX);
      add_chk(FN_COMPLETE, 0, 0, 5, 0, 0, 0, 0, 0, STAT_NO_RUN);
      add_chk(FN_SPARE_LO, 15, '1, '1, 0, 0, 0, 0, 0, STAT_OK);
      add_chk(FN_SPARE_HI, 0, 0, 0, 0, 0, 0, 0, 0, STAT_OK);
      // oversized count clamps to the full table
      add_csr(5'd31);
      add_req(FN_SET_PERIOD, 15, 31'h7FFF_FFFF, 0);
      add_req(FN_SET_PERIOD, 0, 0, 0);
      add_req(FN_ENABLE, 0, 0, 0);
      add_req(FN_ENABLE, 15, 0, 0);
      add_chk(FN_DISPATCH, 0, 0, 0, 0, 0, 0, 0, 0, STAT_OK);
      add_chk(FN_DISPATCH, 0, 0, 1, 1, 0, 1, 0, 0, STAT_OK);
      add_chk(FN_COMPLETE, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, STAT_OK);
      add_chk(FN_COMPLETE, 0, 0, 3, 0, 0, 0, 0, 0, STAT_NO_RUN);
      add_chk(FN_DISPATCH, 0, 0, 32'h8000_0001, 0, 0, 0, 0, 0, STAT_OK);
      add_chk(FN_DISPATCH, 0, 0, 32'h8000_0000, 1, 0, 32'h7FFF_FFFF, 0, 0, STAT_OK);
      add_req(FN_SET_PERIOD, 15, 5, 0);
      add_req(FN_DISABLE, 0, 0, 0);
      add_chk(FN_DISPATCH, 0, 0, 6, 1, 15, 6, 0, 0, STAT_OK);
      add_chk(FN_COMPLETE, 0, 0, 16, 0, 15, 0, 10, 10, STAT_OK);
      add_chk(FN_DISPATCH, 0, 0, 12, 1, 15, 6, 0, 0, STAT_OK);
      // shrink the table under a running task
      add_csr(5'd1);
      add_chk(FN_COMPLETE, 0, 0, 20, 0, 15, 0, 18, 10, STAT_OK);
      add_chk(FN_ENABLE, 1, 0, 0, 0, 0, 0, 0, 0, STAT_BAD_INDEX);
      add_chk(FN_SET_PERIOD, 15, 3, 0, 0, 0, 0, 0, 0, STAT_BAD_INDEX);
      add_chk(FN_DISPATCH, 0, 0, 100, 0, 0, 0, 0, 0, STAT_OK);
      add_req(FN_ENABLE, 0, 0, 0);
      add_chk(FN_DISPATCH, 0, 0, 32'h8000_0005, 1, 0, 5, 0, 0, STAT_OK);
      add_chk(FN_COMPLETE, 0, 0, 32'h8000_0004, 0, 0, 0, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
              STAT_OK);

      phase_cfg[0] = 5'd16;
      phase_cfg[1] = 5'd5;
      phase_cfg[2] = 5'd31;
      phase_cfg[3] = 5'd0;
      phase_cfg[4] = 5'd1;
      phase_cfg[5] = CNT_W'($urandom_range(2, 15));
      phase_cfg[6] = 5'd16;
      phase_cfg[7] = CNT_W'($urandom_range(6, 12));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (script[r]) begin
         if (script[r].kind == ROW_CSR) write_tasks_in_use(script[r].setting);
         else offer(script[r].rq, script[r].pinned, script[r].want);
      end

      // start close to the wrap so the free-running time rolls over mid-run
      now_us = 32'hFFFF_C000;
      for (int ph = 0; ph < PHASES; ph++) begin
         bursts_on = (ph != PHASES - 1);
         write_tasks_in_use(phase_cfg[ph]);
         for (int n = 0; n < PHASE_ITEMS; n++) offer(random_request(), 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Ran %0d requests across %0d table sizes; %0d results checked field by field.",
               requests_sent, settings_used, reports_seen);
      $display("Saw %0d dispatches, %0d completions, %0d bad indices, %0d idle completions.",
               fired, closed, rejected, orphans);
      if (faults == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
